// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define FUST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FUST_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define FUST_ASSERT(name, prop, msg)
`define FUST_ASSERT_IMPL(name, ante, cons, msg)
`endif
`endif

// ===== rtl/fust_pkg.sv =====
// ----------------------------------------------------------------------------
// fust_pkg
// Shared types, codes and helpers of the unique set table.
// ----------------------------------------------------------------------------
package fust_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_W        = 32;
  localparam int MEMBER_COUNT_W = 7;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_DIV3      = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_QUERIED   = 3'd6;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_COMMIT
  } state_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic tok;
    logic hit;
    logic free;
  } link_t;

  // commit broadcast to all cells
  typedef struct packed {
    logic add_en;
    logic rm_en;
  } cmt_t;

  // signed divisibility by three: 4 = 1 (mod 3), and the sign weight -2^31 = 1 (mod 3)
  function automatic logic div_by_three(input logic [VALUE_W-1:0] v);
    logic [5:0] s;
    logic [3:0] a;
    logic [2:0] b;
    s = 6'($countones(v & 32'h5555_5555))
      + {5'($countones(v & 32'hAAAA_AAAA)), 1'b0}
      + {4'd0, v[31], 1'b0};
    a = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
    b = 3'(a[3:2]) + 3'(a[1:0]);
    return (b == 3'd0) || (b == 3'd3);
  endfunction

endpackage

// ===== rtl/fust_ifs.sv =====
// ----------------------------------------------------------------------------
// fust request and response channels
// Valid/ready channels carrying one request or one response.
// ----------------------------------------------------------------------------
interface fust_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] value;
  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface fust_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       was_member;
  logic [6:0] member_count;
  modport source (output valid, output status, output was_member, output member_count,
                  input ready);
  modport sink (input valid, input status, input was_member, input member_count,
                output ready);
endinterface

// ===== rtl/fust_cell.sv =====
// ----------------------------------------------------------------------------
// fust_cell
// One slot of the set: holds a value and its valid bit, checks the search
// token as it passes and applies the commit broadcast.
// ----------------------------------------------------------------------------
module fust_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] key,
  input  fust_pkg::link_t    link_in,
  output fust_pkg::link_t    link_out,
  input  fust_pkg::cmt_t     cmt
);
  import fust_pkg::*;

  logic               valid_r;
  logic signed [31:0] value_r;
  logic               hit_mark_r;
  logic               free_mark_r;
  link_t              link_r;
  logic               match;

  assign match    = valid_r && (value_r == key);
  assign link_out = link_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      hit_mark_r  <= 1'b0;
      free_mark_r <= 1'b0;
      link_r      <= '0;
    end else begin
      link_r.tok  <= link_in.tok;
      link_r.hit  <= link_in.hit | match;
      link_r.free <= link_in.free | !valid_r;
      if (link_in.tok) begin
        hit_mark_r  <= match;
        free_mark_r <= !valid_r && !link_in.free;
      end
      if (cmt.add_en && free_mark_r) begin
        valid_r <= 1'b1;
      end else if (cmt.rm_en && hit_mark_r) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmt.add_en && free_mark_r) begin
      value_r <= key;
    end
  end

endmodule

// ===== rtl/fust_ctrl.sv =====
// ----------------------------------------------------------------------------
// fust_ctrl
// Sequencer: takes a request, sends the search token down the cell chain,
// decides the status at the tail and commits the update and the response.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fust_ctrl #(
  parameter int CAPACITY = fust_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  fust_req_if.sink           req,
  fust_rsp_if.source         rsp,
  output logic signed [31:0] key,
  output fust_pkg::link_t    head,
  input  fust_pkg::link_t    tail,
  output fust_pkg::cmt_t     cmt
);
  import fust_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t             state_r, state_nxt;
  logic               start_r;
  logic [1:0]         op_r;
  logic signed [31:0] key_r;
  logic               div3_r;
  logic               hit_r;
  logic               free_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r;
  logic               out_member_r;
  logic               accept;
  logic               commit_go;
  logic [2:0]         status;

  assign accept = req.valid && req.ready;
  assign key    = key_r;
  assign head   = '{tok: start_r, hit: 1'b0, free: 1'b0};

  always_comb begin
    priority if (op_r == OP_ADD) begin
      if (div3_r)      status = ST_DIV3;
      else if (hit_r)  status = ST_DUPLICATE;
      else if (!free_r) status = ST_FULL;
      else             status = ST_ADDED;
    end else if (op_r == OP_REMOVE) begin
      status = hit_r ? ST_REMOVED : ST_NOT_FOUND;
    end else begin
      status = ST_QUERIED;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE:   if (accept) state_nxt = FSM_SEARCH;
      FSM_SEARCH: if (tail.tok) state_nxt = FSM_COMMIT;
      FSM_COMMIT: if (!out_valid_r || rsp.ready) state_nxt = FSM_IDLE;
      default:    state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = (state_r == FSM_IDLE);
    commit_go  = (state_r == FSM_COMMIT) && (!out_valid_r || rsp.ready);
    cmt.add_en = commit_go && (status == ST_ADDED);
    cmt.rm_en  = commit_go && (status == ST_REMOVED);
    count_nxt  = count_r;
    if (cmt.add_en) count_nxt = count_r + CNT_W'(1);
    else if (cmt.rm_en) count_nxt = count_r - CNT_W'(1);
    if (commit_go) out_valid_nxt = 1'b1;
    else if (rsp.ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      start_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= accept;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= req.opcode;
      key_r  <= req.value;
      div3_r <= div_by_three(req.value);
    end
    if ((state_r == FSM_SEARCH) && tail.tok) begin
      hit_r  <= tail.hit;
      free_r <= tail.free;
    end
    if (commit_go) begin
      out_status_r <= status;
      out_member_r <= hit_r;
    end
  end

  assign rsp.valid        = out_valid_r;
  assign rsp.status       = out_status_r;
  assign rsp.was_member   = out_member_r;
  assign rsp.member_count = MEMBER_COUNT_W'(count_r);

  `FUST_ASSERT(a_count_bound, count_r <= CAPACITY, "held count above capacity")
  `FUST_ASSERT_IMPL(a_tail_in_search, tail.tok, state_r == FSM_SEARCH,
                    "search token left the chain outside a search")
  `FUST_ASSERT_IMPL(a_accept_starts, accept, ##1 (start_r && state_r == FSM_SEARCH),
                    "accepted request did not start a search")
  `FUST_ASSERT_IMPL(a_add_legal, cmt.add_en, free_r && !hit_r && !div3_r,
                    "add committed without a free slot or with a match")
  `FUST_ASSERT_IMPL(a_rm_legal, cmt.rm_en, hit_r && (count_r != '0),
                    "remove committed without a matching slot")

endmodule

// ===== rtl/filtered_unique_set_table.sv =====
// ----------------------------------------------------------------------------
// filtered_unique_set_table
// Set of distinct signed 32-bit values kept in a chain of slot cells.
// ----------------------------------------------------------------------------
// Channels: in_if carries one request (opcode add, remove or query, and a
// value); out_if returns one response per request with a status, whether the
// value was held before, and the count of values held afterwards.
// A request is taken only while the block is idle. A search token then walks
// the chain one cell per cycle; when it leaves the tail the status is decided,
// the update is committed and the response is loaded into the output register,
// and only then does the block return to idle, so the next request is not
// taken before the response to the previous one has been loaded.
// Adds refused for divisibility by three, duplicates or a full set, and
// removes of absent values, change nothing.
// Reset (rst_n low, synchronous) empties the set and clears the count; slot
// values are written only on add.
// If the receiver stalls, the response holds in the output register and the
// block waits after the search, before committing the next update.
// ----------------------------------------------------------------------------
module filtered_unique_set_table #(
  parameter int CAPACITY = fust_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  fust_req_if.sink   in_if,
  fust_rsp_if.source out_if
);
  import fust_pkg::*;

  logic signed [31:0] key;
  cmt_t               cmt;
  link_t              chain [CAPACITY+1];

  fust_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (in_if),
    .rsp   (out_if),
    .key   (key),
    .head  (chain[0]),
    .tail  (chain[CAPACITY]),
    .cmt   (cmt)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    fust_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key),
      .link_in  (chain[i]),
      .link_out (chain[i+1]),
      .cmt      (cmt)
    );
  end

endmodule
